### src/mrnc_pkg.sv
`timescale 1ns / 1ps
// Shared types, field widths and codes for the neighbour counter.
package mrnc_pkg;

  localparam int ID_W       = 20;
  localparam int POS_W      = 20;
  localparam int QIDX_W     = 10;
  localparam int COUNT_W    = 10;
  localparam int STORED_W   = 11;
  localparam int RSQ_W      = 44;
  localparam int RIU_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 44;
  localparam int NUM_COUNT_OUT = 4;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int MAX_RADII_DEF  = 4;
  localparam int COORD_BITS_DEF = 20;

  // register stages of the distance unit, and cycles to flush RAM plus that unit
  localparam int DIST_LAT  = 3;
  localparam int DRAIN_CYC = DIST_LAT + 1;

  localparam logic [COUNT_W-1:0]  COUNT_MAX  = 10'd1023;
  localparam logic [STORED_W-1:0] STORED_MAX = 11'd2047;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_NOT_STORED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RADII_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ_0  = 3'd1;

  typedef struct packed {
    logic [1:0]              operation;
    logic [ID_W-1:0]         point_id;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic signed [POS_W-1:0] z_pos;
    logic [QIDX_W-1:0]       query_index;
  } point_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [ID_W-1:0]     result_id;
    logic [COUNT_W-1:0]  count_r0;
    logic [COUNT_W-1:0]  count_r1;
    logic [COUNT_W-1:0]  count_r2;
    logic [COUNT_W-1:0]  count_r3;
    logic [STORED_W-1:0] stored_points;
  } result_item_t;

endpackage

### src/mrnc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mrnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/mrnc_dist.sv
`timescale 1ns / 1ps
// Pipelined squared distance between a stored point and the query point.
module mrnc_dist import mrnc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int D2_W       = 2 * COORD_BITS_DEF + 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [ID_W-1:0]       entry_id,
  input  logic [COORD_BITS-1:0] entry_x,
  input  logic [COORD_BITS-1:0] entry_y,
  input  logic [COORD_BITS-1:0] entry_z,
  input  logic [ID_W-1:0]       ref_id,
  input  logic [COORD_BITS-1:0] ref_x,
  input  logic [COORD_BITS-1:0] ref_y,
  input  logic [COORD_BITS-1:0] ref_z,
  output logic                  out_valid,
  output logic                  out_skip,
  output logic [D2_W-1:0]       d2
);

  localparam int MAG_W = COORD_BITS + 1;
  localparam int SQ_W  = 2 * MAG_W;

  logic [COORD_BITS-1:0] a [3];
  logic [COORD_BITS-1:0] b [3];
  logic signed [MAG_W-1:0] diff [3];
  logic [MAG_W-1:0] mag_next [3];
  logic [MAG_W-1:0] mag [3];
  logic [SQ_W-1:0]  sq [3];
  logic v1, v2, skip1, skip2;

  assign a[0] = entry_x;
  assign a[1] = entry_y;
  assign a[2] = entry_z;
  assign b[0] = ref_x;
  assign b[1] = ref_y;
  assign b[2] = ref_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({a[k][COORD_BITS-1], a[k]}) - $signed({b[k][COORD_BITS-1], b[k]});
      mag_next[k] = diff[k][MAG_W-1] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    skip1 <= (entry_id == ref_id);
    skip2 <= skip1;
    out_skip <= skip2;
    for (int k = 0; k < 3; k++) begin
      mag[k] <= mag_next[k];
      sq[k]  <= SQ_W'(mag[k]) * SQ_W'(mag[k]);
    end
    d2 <= D2_W'(sq[0]) + D2_W'(sq[1]) + D2_W'(sq[2]);
  end

endmodule

### src/mrnc_cut.sv
`timescale 1ns / 1ps
// Per-radius compare and saturating neighbour counters.
module mrnc_cut import mrnc_pkg::*; #(
  parameter int MAX_RADII = MAX_RADII_DEF,
  parameter int D2_W      = 2 * COORD_BITS_DEF + 4
) (
  input  logic                                 clk,
  input  logic                                 clear,
  input  logic                                 valid,
  input  logic [D2_W-1:0]                      d2,
  input  logic [MAX_RADII-1:0][RSQ_W-1:0]      radius_sq,
  input  logic [RIU_W-1:0]                     active,
  output logic [MAX_RADII-1:0][COUNT_W-1:0]    counts
);

  localparam int CMP_W = (D2_W > RSQ_W) ? D2_W : RSQ_W;

  for (genvar r = 0; r < MAX_RADII; r++) begin : g_lane
    logic hit;
    logic [COUNT_W-1:0] cnt;

    assign hit = valid && (RIU_W'(r) < active) &&
                 (CMP_W'(d2) < CMP_W'(radius_sq[r]));

    always_ff @(posedge clk) begin
      if (clear) begin
        cnt <= '0;
      end else if (hit && cnt != COUNT_MAX) begin
        cnt <= cnt + COUNT_W'(1);
      end
    end

    assign counts[r] = cnt;
  end

endmodule

### src/multi_radius_neighbour_count.sv
`timescale 1ns / 1ps
// Top level of the multi-radius neighbour counter.
//
// Items enter on item/item_valid/item_stall, results leave on
// result/result_valid/result_stall; an item moves at an edge with valid high
// and stall low. Each item gives exactly one result. Configuration is written
// through cfg_write/cfg_index/cfg_data; the user must do so only while the
// block is idle, which the block itself does not enforce. Clear and add go
// from acceptance through the finish state to the output register. A query
// reads the queried point from RAM, then each stored point on the single read
// port, flushes RAM and the three-stage distance pipe, then posts the result.
// Only one item is in work at a time; item_stall is high while it runs.
// The output register holds a result while result_stall is high, and the next
// item can already be taken and worked on meanwhile.
// Synchronous reset empties the store, sets radii_in_use to 1 and all radii
// to zero; the point RAM itself is not cleared, entries are read only after
// an add wrote them.
module multi_radius_neighbour_count import mrnc_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int MAX_RADII  = MAX_RADII_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  point_item_t           item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_item_t          result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W  = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int ENTRY_W = ID_W + 3 * COORD_BITS;
  localparam int D2_W    = 2 * COORD_BITS + 4;
  localparam int QCMP_W  = (CNT_W > QIDX_W) ? CNT_W : QIDX_W;
  localparam int SCMP_W  = (CNT_W > STORED_W) ? CNT_W : STORED_W;
  localparam int DRAIN_W = $clog2(DRAIN_CYC);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REF    = 5'b00010,
    S_WALK   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } entry_t;

  state_t state;
  logic [CNT_W-1:0] point_count;
  logic [CNT_W-1:0] walk_idx;
  logic [CNT_W-1:0] walk_inc;
  logic [DRAIN_W-1:0] drain_cnt;
  logic [RIU_W-1:0] radii_in_use;
  logic [RIU_W-1:0] radii_active;
  logic [MAX_RADII-1:0][RSQ_W-1:0] radius_sq;
  logic [MAX_RADII-1:0][COUNT_W-1:0] counts;
  logic [NUM_COUNT_OUT-1:0][COUNT_W-1:0] count_out;

  logic accept, q_ok, store_full, issue, rd_v;
  logic wr_en, rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t wr_entry, rd_entry, ref_entry;

  logic dist_valid, dist_skip;
  logic [D2_W-1:0] d2;

  logic [1:0] hold_status;
  logic [ID_W-1:0] hold_id;
  logic hold_query;
  logic [STORED_W-1:0] stored_sat;
  result_item_t result_next;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign q_ok       = QCMP_W'(item.query_index) < QCMP_W'(point_count);
  assign store_full = point_count >= CNT_W'(MAX_POINTS);
  assign issue      = (state == S_REF) || (state == S_WALK);
  assign walk_inc   = walk_idx + CNT_W'(1);

  assign radii_active = (radii_in_use > RIU_W'(MAX_RADII)) ? RIU_W'(MAX_RADII) : radii_in_use;

  // coordinate fields are taken as raw bits, then read as COORD_BITS two's complement
  assign wr_entry.id = item.point_id;
  assign wr_entry.x  = COORD_BITS'($unsigned(item.x_pos));
  assign wr_entry.y  = COORD_BITS'($unsigned(item.y_pos));
  assign wr_entry.z  = COORD_BITS'($unsigned(item.z_pos));

  assign wr_en   = accept && (item.operation == OP_ADD) && !store_full;
  assign rd_en   = (accept && (item.operation == OP_QUERY) && q_ok) || issue;
  assign rd_addr = (state == S_IDLE) ? ADDR_W'(item.query_index) : walk_idx[ADDR_W-1:0];

  mrnc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (point_count[ADDR_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  mrnc_dist #(
    .COORD_BITS (COORD_BITS),
    .D2_W       (D2_W)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_v),
    .entry_id  (rd_entry.id),
    .entry_x   (rd_entry.x),
    .entry_y   (rd_entry.y),
    .entry_z   (rd_entry.z),
    .ref_id    (ref_entry.id),
    .ref_x     (ref_entry.x),
    .ref_y     (ref_entry.y),
    .ref_z     (ref_entry.z),
    .out_valid (dist_valid),
    .out_skip  (dist_skip),
    .d2        (d2)
  );

  mrnc_cut #(
    .MAX_RADII (MAX_RADII),
    .D2_W      (D2_W)
  ) u_cut (
    .clk       (clk),
    .clear     (accept),
    .valid     (dist_valid && !dist_skip),
    .d2        (d2),
    .radius_sq (radius_sq),
    .active    (radii_active),
    .counts    (counts)
  );

  for (genvar r = 0; r < NUM_COUNT_OUT; r++) begin : g_count_out
    if (r < MAX_RADII) begin : g_used
      assign count_out[r] = hold_query ? counts[r] : '0;
    end else begin : g_unused
      assign count_out[r] = '0;
    end
  end

  assign stored_sat = (SCMP_W'(point_count) > SCMP_W'(STORED_MAX)) ?
                      STORED_MAX : STORED_W'(point_count);

  always_comb begin
    result_next.status        = hold_status;
    result_next.result_id     = hold_id;
    result_next.count_r0      = count_out[0];
    result_next.count_r1      = count_out[1];
    result_next.count_r2      = count_out[2];
    result_next.count_r3      = count_out[3];
    result_next.stored_points = stored_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      point_count  <= '0;
      result_valid <= 1'b0;
      rd_v         <= 1'b0;
      radii_in_use <= RIU_W'(1);
      radius_sq    <= '0;
    end else begin
      rd_v <= issue;
      // the finish state reloads the output register itself
      if (result_valid && !result_stall && state != S_FINISH) begin
        result_valid <= 1'b0;
      end

      if (cfg_write) begin
        if (cfg_index == CFG_RADII_IN_USE) begin
          radii_in_use <= cfg_data[RIU_W-1:0];
        end
        for (int r = 0; r < MAX_RADII; r++) begin
          if (cfg_index == CFG_IDX_W'(int'(CFG_RADIUS_SQ_0) + r)) begin
            radius_sq[r] <= cfg_data[RSQ_W-1:0];
          end
        end
      end

      unique case (state) inside
        S_IDLE: begin
          if (accept) begin
            hold_id    <= '0;
            hold_query <= 1'b0;
            walk_idx   <= '0;
            case (item.operation)
              OP_CLEAR: begin
                point_count <= '0;
                hold_status <= ST_OK;
                state       <= S_FINISH;
              end
              OP_ADD: begin
                state <= S_FINISH;
                if (store_full) begin
                  hold_status <= ST_FULL;
                end else begin
                  hold_status <= ST_OK;
                  point_count <= point_count + CNT_W'(1);
                end
              end
              OP_QUERY: begin
                if (q_ok) begin
                  hold_status <= ST_OK;
                  state       <= S_REF;
                end else begin
                  hold_status <= ST_NOT_STORED;
                  state       <= S_FINISH;
                end
              end
              default: begin
                hold_status <= ST_OK;
                state       <= S_FINISH;
              end
            endcase
          end
        end
        S_REF, S_WALK: begin
          if (state == S_REF) begin
            ref_entry  <= rd_entry;
            hold_id    <= rd_entry.id;
            hold_query <= 1'b1;
          end
          walk_idx <= walk_inc;
          if (walk_inc == point_count) begin
            drain_cnt <= DRAIN_W'(DRAIN_CYC - 1);
            state     <= S_DRAIN;
          end else begin
            state <= S_WALK;
          end
        end
        S_DRAIN: begin
          if (drain_cnt == '0) begin
            state <= S_FINISH;
          end else begin
            drain_cnt <= drain_cnt - DRAIN_W'(1);
          end
        end
        S_FINISH: begin
          if (!result_valid || !result_stall) begin
            result       <= result_next;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/mrnc_check.sv
`timescale 1ns / 1ps
// Port-level checks for the neighbour counter, bound to the top level.
module mrnc_check import mrnc_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  item_valid,
  input logic                  item_stall,
  input logic                  result_valid,
  input logic                  result_stall,
  input result_item_t          result
);

  localparam logic [STORED_W-1:0] FULL_LEVEL =
    (MAX_POINTS > int'(STORED_MAX)) ? STORED_MAX : STORED_W'(MAX_POINTS);

  // a held result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // only one item in work: the cycle after acceptance the input is stalled
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item taken while another item is in work");

  // error results carry no id and no counts
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |->
      result.result_id == '0 && result.count_r0 == '0 && result.count_r1 == '0 &&
      result.count_r2 == '0 && result.count_r3 == '0)
    else $error("error result with nonzero payload");

  // store full is only reported with the store at capacity
  a_full_level: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_FULL |-> result.stored_points == FULL_LEVEL)
    else $error("store full reported below capacity");

endmodule

bind multi_radius_neighbour_count mrnc_check #(.MAX_POINTS(MAX_POINTS)) u_mrnc_check (.*);
